// ===== sv/vne_pkg.sv =====
// Package for the voxel neighbour enumerator: shared codes, command/status types
// and the constant slot tables. No dependencies.
`default_nettype none

package vne_pkg;

   // Offset of a neighbour along one axis, relative to the centre voxel.
   typedef logic [1:0] delta_type;
   localparam delta_type D_ZERO  = 2'd0;
   localparam delta_type D_MINUS = 2'd1;
   localparam delta_type D_PLUS  = 2'd2;

   // Slot layout: three slices of nine voxels each.
   localparam int NUM_SLOTS   = 27;
   localparam int SLICE_SLOTS = 9;

   // Setup sequence on the shared multiplier.
   localparam int SETUP_STEPS = 7;
   localparam int STEP_BITS   = $clog2(SETUP_STEPS);

   // Product kinds computed during setup.
   typedef logic [1:0] mul_kind_type;
   localparam mul_kind_type MUL_SXY = 2'd0;
   localparam mul_kind_type MUL_YT  = 2'd1;
   localparam mul_kind_type MUL_ZT  = 2'd2;

   // Configuration register map.
   localparam int CSR_ADDR_W = 4;
   typedef logic [CSR_ADDR_W-3:0] reg_idx_type;
   localparam reg_idx_type REG_SIZE_X = 2'd0;
   localparam reg_idx_type REG_SIZE_Y = 2'd1;
   localparam reg_idx_type REG_SIZE_Z = 2'd2;

   localparam int SIZE_X_RESET = 1024;
   localparam int SIZE_Y_RESET = 1024;
   localparam int SIZE_Z_RESET = 1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         capture;
      logic         mul_en;
      mul_kind_type mul_kind;
      delta_type    mul_sel;
      logic         load_out;
      delta_type    dx;
      delta_type    dy;
      delta_type    dz;
      logic         last;
   } dp_cmd_type;

   // Neighbour existence flags reported by the datapath.
   typedef struct packed {
      logic lo_x;
      logic hi_x;
      logic lo_y;
      logic hi_y;
      logic lo_z;
      logic hi_z;
   } dp_stat_type;

   // X offset of a slot: centre, left (three), top, bottom, right (three).
   function automatic delta_type slot_dx(input int k);
      case (k % SLICE_SLOTS)
         0, 4, 5: slot_dx = D_ZERO;
         1, 2, 3: slot_dx = D_MINUS;
         default: slot_dx = D_PLUS;
      endcase
   endfunction

   // Y offset of a slot within its slice.
   function automatic delta_type slot_dy(input int k);
      case (k % SLICE_SLOTS)
         0, 1, 6: slot_dy = D_ZERO;
         2, 4, 7: slot_dy = D_MINUS;
         default: slot_dy = D_PLUS;
      endcase
   endfunction

   // Z offset of a slot: centre slice, then front, then back.
   function automatic delta_type slot_dz(input int k);
      case (k / SLICE_SLOTS)
         0:       slot_dz = D_ZERO;
         1:       slot_dz = D_MINUS;
         default: slot_dz = D_PLUS;
      endcase
   endfunction

   // True when an offset along one axis leads to an existing voxel.
   function automatic logic delta_ok(input delta_type d, input logic lo, input logic hi);
      case (d)
         D_ZERO:  delta_ok = 1'b1;
         D_MINUS: delta_ok = lo;
         D_PLUS:  delta_ok = hi;
         default: delta_ok = 1'b0;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== sv/vne_if.sv =====
// Channel interfaces of the voxel neighbour enumerator: request (centre voxel)
// and response (one neighbour per transfer). No dependencies.
`default_nettype none

interface vne_req_if #(
   parameter int DIM_BITS = 10
);
   logic                valid;
   logic                ready;
   logic                mode;
   logic [DIM_BITS-1:0] coord_x;
   logic [DIM_BITS-1:0] coord_y;
   logic [DIM_BITS-1:0] coord_z;

   modport source (output valid, mode, coord_x, coord_y, coord_z, input ready);
   modport sink   (input valid, mode, coord_x, coord_y, coord_z, output ready);
endinterface

interface vne_rsp_if #(
   parameter int DIM_BITS = 10
);
   logic                  valid;
   logic                  ready;
   logic [DIM_BITS-1:0]   nbr_x;
   logic [DIM_BITS-1:0]   nbr_y;
   logic [DIM_BITS-1:0]   nbr_z;
   logic [3*DIM_BITS-1:0] nbr_linear;
   logic                  last;

   modport source (output valid, nbr_x, nbr_y, nbr_z, nbr_linear, last, input ready);
   modport sink   (input valid, nbr_x, nbr_y, nbr_z, nbr_linear, last, output ready);
endinterface

`default_nettype wire

// ===== sv/vne_csr.sv =====
// Volume size registers behind the APB-style configuration port.
// Depends on vne_pkg.
`default_nettype none

module vne_csr import vne_pkg::*; #(
   parameter int DIM_BITS = 10,
   localparam int SIZE_W  = DIM_BITS + 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready,
   output logic      [SIZE_W-1:0]     size_x,
   output logic      [SIZE_W-1:0]     size_y,
   output logic      [SIZE_W-1:0]     size_z
);

   logic [SIZE_W-1:0] size_x_ff, size_x_in;
   logic [SIZE_W-1:0] size_y_ff, size_y_in;
   logic [SIZE_W-1:0] size_z_ff, size_z_in;
   reg_idx_type       reg_idx;
   logic              wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // Register write decode; writes past the map are dropped.
   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SIZE_X: size_x_in = pwdata[SIZE_W-1:0];
            REG_SIZE_Y: size_y_in = pwdata[SIZE_W-1:0];
            REG_SIZE_Z: size_z_in = pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      case (reg_idx)
         REG_SIZE_X: prdata = 32'(size_x_ff);
         REG_SIZE_Y: prdata = 32'(size_y_ff);
         REG_SIZE_Z: prdata = 32'(size_z_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_W'(SIZE_X_RESET);
         size_y_ff <= SIZE_W'(SIZE_Y_RESET);
         size_z_ff <= SIZE_W'(SIZE_Z_RESET);
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
      end
   end

   assign size_x = size_x_ff;
   assign size_y = size_y_ff;
   assign size_z = size_z_ff;

endmodule

`default_nettype wire

// ===== sv/vne_datapath.sv =====
// Datapath: centre voxel registers, shared multiplier for the linear-index
// terms, neighbour flags and the response register. Depends on vne_pkg.
`default_nettype none

module vne_datapath import vne_pkg::*; #(
   parameter int DIM_BITS = 10,
   localparam int SIZE_W  = DIM_BITS + 1,
   localparam int LIN_W   = 3 * DIM_BITS,
   localparam int SXY_W   = 2 * SIZE_W,
   localparam int PROD_W  = SXY_W + SIZE_W
) (
   input  wire logic                clock,
   input  wire dp_cmd_type          cmd,
   output dp_stat_type              stat,
   input  wire logic                req_mode,
   input  wire logic [DIM_BITS-1:0] req_coord_x,
   input  wire logic [DIM_BITS-1:0] req_coord_y,
   input  wire logic [DIM_BITS-1:0] req_coord_z,
   input  wire logic [SIZE_W-1:0]   size_x,
   input  wire logic [SIZE_W-1:0]   size_y,
   input  wire logic [SIZE_W-1:0]   size_z,
   output logic      [DIM_BITS-1:0] rsp_nbr_x,
   output logic      [DIM_BITS-1:0] rsp_nbr_y,
   output logic      [DIM_BITS-1:0] rsp_nbr_z,
   output logic      [LIN_W-1:0]    rsp_nbr_linear,
   output logic                     rsp_last
);

   logic                mode_ff, mode_in;
   logic [DIM_BITS-1:0] x_ff, x_in;
   logic [DIM_BITS-1:0] y_ff, y_in;
   logic [DIM_BITS-1:0] z_ff, z_in;
   logic [SXY_W-1:0]    sxy_ff, sxy_in;
   logic [LIN_W-1:0]    yterm_ff [3];
   logic [LIN_W-1:0]    yterm_in [3];
   logic [LIN_W-1:0]    zterm_ff [3];
   logic [LIN_W-1:0]    zterm_in [3];
   logic [DIM_BITS-1:0] nx_ff, nx_in;
   logic [DIM_BITS-1:0] ny_ff, ny_in;
   logic [DIM_BITS-1:0] nz_ff, nz_in;
   logic [LIN_W-1:0]    lin_ff, lin_in;
   logic                last_ff, last_in;

   logic [SXY_W-1:0]    mul_a;
   logic [SIZE_W-1:0]   mul_b;
   logic [PROD_W-1:0]   mul_p;
   logic [DIM_BITS-1:0] sel_x, sel_y, sel_z;
   logic [LIN_W-1:0]    sel_yt, sel_zt;

   // Coordinate of the centre moved by one offset, wrapped to the field width.
   function automatic logic [DIM_BITS-1:0] move(input delta_type d,
                                                input logic [DIM_BITS-1:0] c);
      case (d)
         D_MINUS: move = c - DIM_BITS'(1);
         D_PLUS:  move = c + DIM_BITS'(1);
         default: move = c;
      endcase
   endfunction

   // Existence of the lower and upper neighbours along each axis.
   always_comb begin
      stat.lo_x = (x_ff != '0);
      stat.hi_x = (({1'b0, x_ff} + SIZE_W'(1)) < size_x);
      stat.lo_y = (y_ff != '0);
      stat.hi_y = (({1'b0, y_ff} + SIZE_W'(1)) < size_y);
      stat.lo_z = mode_ff && (z_ff != '0);
      stat.hi_z = mode_ff && (({1'b0, z_ff} + SIZE_W'(1)) < size_z);
   end

   // Shared multiplier: size_x*size_y, then row terms, then slice terms.
   always_comb begin
      case (cmd.mul_kind)
         MUL_SXY: begin
            mul_a = SXY_W'(size_x);
            mul_b = size_y;
         end
         MUL_YT: begin
            mul_a = SXY_W'(move(cmd.mul_sel, y_ff));
            mul_b = size_x;
         end
         default: begin
            mul_a = sxy_ff;
            mul_b = SIZE_W'(move(cmd.mul_sel, z_ff));
         end
      endcase
      mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // Per-slot selection of coordinates and precomputed terms.
   always_comb begin
      sel_x = move(cmd.dx, x_ff);
      sel_y = move(cmd.dy, y_ff);
      sel_z = move(cmd.dz, z_ff);
      case (cmd.dy)
         D_MINUS: sel_yt = yterm_ff[D_MINUS];
         D_PLUS:  sel_yt = yterm_ff[D_PLUS];
         default: sel_yt = yterm_ff[D_ZERO];
      endcase
      case (cmd.dz)
         D_MINUS: sel_zt = zterm_ff[D_MINUS];
         D_PLUS:  sel_zt = zterm_ff[D_PLUS];
         default: sel_zt = zterm_ff[D_ZERO];
      endcase
   end

   // Next-state logic of all datapath registers.
   always_comb begin
      mode_in = mode_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      sxy_in  = sxy_ff;
      for (int i = 0; i < 3; i++) begin
         yterm_in[i] = yterm_ff[i];
         zterm_in[i] = zterm_ff[i];
      end
      nx_in   = nx_ff;
      ny_in   = ny_ff;
      nz_in   = nz_ff;
      lin_in  = lin_ff;
      last_in = last_ff;

      if (cmd.capture) begin
         mode_in = req_mode;
         x_in    = req_coord_x;
         y_in    = req_coord_y;
         z_in    = req_coord_z;
      end

      if (cmd.mul_en) begin
         if (cmd.mul_kind == MUL_SXY) begin
            sxy_in = mul_p[SXY_W-1:0];
         end
         for (int i = 0; i < 3; i++) begin
            if (cmd.mul_sel == delta_type'(i)) begin
               if (cmd.mul_kind == MUL_YT) begin
                  yterm_in[i] = mul_p[LIN_W-1:0];
               end
               if (cmd.mul_kind == MUL_ZT) begin
                  zterm_in[i] = mul_p[LIN_W-1:0];
               end
            end
         end
      end

      // Response register: index = slice term + row term + column.
      if (cmd.load_out) begin
         nx_in   = sel_x;
         ny_in   = sel_y;
         nz_in   = sel_z;
         lin_in  = sel_zt + sel_yt + LIN_W'(sel_x);
         last_in = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      sxy_ff  <= sxy_in;
      for (int i = 0; i < 3; i++) begin
         yterm_ff[i] <= yterm_in[i];
         zterm_ff[i] <= zterm_in[i];
      end
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      nz_ff   <= nz_in;
      lin_ff  <= lin_in;
      last_ff <= last_in;
   end

   assign rsp_nbr_x      = nx_ff;
   assign rsp_nbr_y      = ny_ff;
   assign rsp_nbr_z      = nz_ff;
   assign rsp_nbr_linear = lin_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

// ===== sv/vne_ctrl.sv =====
// Controller: request acceptance, setup sequencing of the multiplier, the
// pending-slot mask and the response valid flag. Depends on vne_pkg.
`default_nettype none

module vne_ctrl import vne_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [NUM_SLOTS-1:0] mask_ff, mask_in;
   logic                 out_valid_ff, out_valid_in;

   logic [NUM_SLOTS-1:0] new_mask;
   logic [NUM_SLOTS-1:0] mask_rest;
   delta_type            pick_dx, pick_dy, pick_dz;
   logic                 pick_last;
   logic                 can_load;

   // A slot is pending when every axis offset leads to an existing voxel.
   always_comb begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
         new_mask[k] = delta_ok(slot_dx(k), stat.lo_x, stat.hi_x) &&
                       delta_ok(slot_dy(k), stat.lo_y, stat.hi_y) &&
                       delta_ok(slot_dz(k), stat.lo_z, stat.hi_z);
      end
   end

   // Lowest pending slot goes out next; it is the last one when none remains.
   always_comb begin
      pick_dx = D_ZERO;
      pick_dy = D_ZERO;
      pick_dz = D_ZERO;
      for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            pick_dx = slot_dx(k);
            pick_dy = slot_dy(k);
            pick_dz = slot_dz(k);
         end
      end
      mask_rest = mask_ff & (mask_ff - NUM_SLOTS'(1));
      pick_last = (mask_rest == '0);
   end

   assign can_load = !out_valid_ff || rsp_ready;

   // Main sequencer.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      mask_in      = mask_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      cmd          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               step_in     = '0;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.mul_en = 1'b1;
            case (step_ff)
               STEP_BITS'(0): begin cmd.mul_kind = MUL_SXY; cmd.mul_sel = D_ZERO;  end
               STEP_BITS'(1): begin cmd.mul_kind = MUL_YT;  cmd.mul_sel = D_ZERO;  end
               STEP_BITS'(2): begin cmd.mul_kind = MUL_YT;  cmd.mul_sel = D_MINUS; end
               STEP_BITS'(3): begin cmd.mul_kind = MUL_YT;  cmd.mul_sel = D_PLUS;  end
               STEP_BITS'(4): begin cmd.mul_kind = MUL_ZT;  cmd.mul_sel = D_ZERO;  end
               STEP_BITS'(5): begin cmd.mul_kind = MUL_ZT;  cmd.mul_sel = D_MINUS; end
               STEP_BITS'(6): begin cmd.mul_kind = MUL_ZT;  cmd.mul_sel = D_PLUS;  end
               default:       begin cmd.mul_kind = MUL_SXY; cmd.mul_sel = D_ZERO;  end
            endcase
            mask_in = new_mask;
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SETUP_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (can_load) begin
               cmd.load_out = 1'b1;
               cmd.dx       = pick_dx;
               cmd.dy       = pick_dy;
               cmd.dz       = pick_dz;
               cmd.last     = pick_last;
               out_valid_in = 1'b1;
               mask_in      = mask_rest;
               if (pick_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

// ===== sv/voxel_neighbour_enumerator_top.sv =====
// Top level of the voxel neighbour enumerator: configuration registers,
// controller and datapath. Depends on vne_pkg, vne_if, vne_csr, vne_ctrl, vne_datapath.
//
//   Port group  Direction  Carries
//   req_ch      in         centre voxel coordinates and neighbourhood mode
//   rsp_ch      out        one voxel per transfer: coordinates, linear index, last
//   p* (APB)    in/out     size_x, size_y, size_z at byte addresses 0, 4, 8
//
// In setup, after a request is accepted, one shared multiplier forms
// size_x*size_y and the row and slice terms of the linear index.
// After that, while the sink does not stall, one voxel per cycle goes to the
// response register, 1 to 27 of them in all.
// A new request is taken once the last voxel is in the response register,
// even while that voxel still waits for its transfer. Reset is synchronous.
`default_nettype none

module voxel_neighbour_enumerator_top import vne_pkg::*; #(
   parameter int DIM_BITS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   vne_req_if.sink                    req_ch,
   vne_rsp_if.source                  rsp_ch,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready
);

   localparam int SIZE_W = DIM_BITS + 1;

   logic [SIZE_W-1:0] size_x;
   logic [SIZE_W-1:0] size_y;
   logic [SIZE_W-1:0] size_z;
   dp_cmd_type        cmd;
   dp_stat_type       stat;

   vne_csr #(
      .DIM_BITS (DIM_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .size_x  (size_x),
      .size_y  (size_y),
      .size_z  (size_z)
   );

   vne_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   vne_datapath #(
      .DIM_BITS (DIM_BITS)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .stat           (stat),
      .req_mode       (req_ch.mode),
      .req_coord_x    (req_ch.coord_x),
      .req_coord_y    (req_ch.coord_y),
      .req_coord_z    (req_ch.coord_z),
      .size_x         (size_x),
      .size_y         (size_y),
      .size_z         (size_z),
      .rsp_nbr_x      (rsp_ch.nbr_x),
      .rsp_nbr_y      (rsp_ch.nbr_y),
      .rsp_nbr_z      (rsp_ch.nbr_z),
      .rsp_nbr_linear (rsp_ch.nbr_linear),
      .rsp_last       (rsp_ch.last)
   );

endmodule

`default_nettype wire
